FILE: sv/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared constants, types and helpers of the RC pulse width capture block.
// ----------------------------------------------------------------------------
package rpwc_pkg;

  // block configuration
  localparam int CHANNELS       = 6;
  localparam int TICKS_PER_UNIT = 800;
  localparam int AVERAGE_LENGTH = 5;

  // field widths
  localparam int CHAN_W      = 3;
  localparam int TS_W        = 24;
  localparam int VAL_W       = 8;
  localparam int SUM_W       = 11;
  localparam int CNT_W       = 3;
  localparam int MASK_W      = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [TS_W-1:0]  TS_MAX  = {TS_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // register reset values
  localparam logic [TS_W-1:0]   NARROW_LOW_RST   = TS_W'(79998);
  localparam logic [TS_W-1:0]   NARROW_HIGH_RST  = TS_W'(160002);
  localparam logic [TS_W-1:0]   WIDE_LOW_RST     = TS_W'(71998);
  localparam logic [TS_W-1:0]   WIDE_HIGH_RST    = TS_W'(200002);
  localparam logic [MASK_W-1:0] WIDE_MASK_RST    = MASK_W'(12);
  localparam logic [MASK_W-1:0] AVERAGE_MASK_RST = MASK_W'(58);

  // exact division by reciprocal: floor(n / d) = (n * ceil(2^(N+l) / d)) >> (N+l)
  localparam int T_SHIFT   = TS_W + $clog2(TICKS_PER_UNIT);
  localparam int T_RECIP_W = TS_W + 2;
  localparam longint unsigned T_RECIP_L =
    ((64'd1 << T_SHIFT) + 64'(TICKS_PER_UNIT) - 64'd1) / 64'(TICKS_PER_UNIT);
  localparam logic [T_RECIP_W-1:0] T_RECIP = T_RECIP_W'(T_RECIP_L);
  localparam int T_PROD_W  = TS_W + T_RECIP_W;

  localparam int A_SHIFT   = SUM_W + $clog2(AVERAGE_LENGTH);
  localparam int A_RECIP_W = SUM_W + 2;
  localparam longint unsigned A_RECIP_L =
    ((64'd1 << A_SHIFT) + 64'(AVERAGE_LENGTH) - 64'd1) / 64'(AVERAGE_LENGTH);
  localparam logic [A_RECIP_W-1:0] A_RECIP = A_RECIP_W'(A_RECIP_L);
  localparam int A_PROD_W  = SUM_W + A_RECIP_W;

  // items in flight inside the datapath, and the result queue sized to cover them
  localparam int PIPE_STAGES = 6;
  localparam int QUEUE_DEPTH = PIPE_STAGES + 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NARROW_LOW   = 3'd0,
    CFG_NARROW_HIGH  = 3'd1,
    CFG_WIDE_LOW     = 3'd2,
    CFG_WIDE_HIGH    = 3'd3,
    CFG_WIDE_MASK    = 3'd4,
    CFG_AVERAGE_MASK = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [TS_W-1:0]   narrow_low;
    logic [TS_W-1:0]   narrow_high;
    logic [TS_W-1:0]   wide_low;
    logic [TS_W-1:0]   wide_high;
    logic [MASK_W-1:0] wide_mask;
    logic [MASK_W-1:0] average_mask;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] channel;
    logic [TS_W-1:0]   width;
    logic              average;
  } width_item_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
  } result_t;

  typedef struct packed {
    logic take;
    logic edge_drop;
    logic scale_drop;
  } credit_t;

  // channels past the mask width read their bit as zero
  function automatic logic mask_bit(logic [MASK_W-1:0] mask, logic [CHAN_W-1:0] ch);
    logic bit_val;
    bit_val = 1'b0;
    if (int'(ch) < MASK_W) begin
      bit_val = mask[ch];
    end
    return bit_val;
  endfunction

endpackage

FILE: sv/rpwc_if.sv
// ----------------------------------------------------------------------------
// rpwc interfaces
// Valid/ready channels for capture events, results and register writes.
// ----------------------------------------------------------------------------
interface rpwc_evt_if;
  import rpwc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [TS_W-1:0]   timestamp;
  modport source (output valid, channel, timestamp, input ready);
  modport sink   (input valid, channel, timestamp, output ready);
endinterface

interface rpwc_res_if;
  import rpwc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [VAL_W-1:0]  stick_value;
  modport source (output valid, out_channel, stick_value, input ready);
  modport sink   (input valid, out_channel, stick_value, output ready);
endinterface

interface rpwc_cfg_if;
  import rpwc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/rpwc_ram.sv
// ----------------------------------------------------------------------------
// rpwc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/rpwc_edge.sv
// ----------------------------------------------------------------------------
// rpwc_edge
// Per-channel edge phase and start time in RAM, width and window check.
// ----------------------------------------------------------------------------
module rpwc_edge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [rpwc_pkg::CHAN_W-1:0]   channel,
  input  logic [rpwc_pkg::TS_W-1:0]     timestamp,
  input  rpwc_pkg::cfg_t                cfg_regs,
  output rpwc_pkg::width_item_t         item,
  output logic                          drop
);
  import rpwc_pkg::*;

  typedef struct packed {
    logic            phase;
    logic [TS_W-1:0] start;
  } edge_entry_t;

  logic                       s1_valid;
  logic [CHAN_W-1:0]          s1_channel;
  logic [TS_W-1:0]            s1_ts;
  logic                       s1_seen;
  logic [CHANNELS-1:0]        seen;
  logic                       fwd_valid;
  logic [CH_W-1:0]            fwd_addr;
  edge_entry_t                fwd_entry;
  logic [CH_W-1:0]            rd_addr;
  logic [CH_W-1:0]            s1_addr;
  logic [$bits(edge_entry_t)-1:0] rd_data;
  edge_entry_t                cur;
  edge_entry_t                upd;
  logic [TS_W-1:0]            width;
  logic [TS_W-1:0]            lo;
  logic [TS_W-1:0]            hi;
  logic                       pass;
  logic                       item_valid;
  logic [CHAN_W-1:0]          item_channel;
  logic [TS_W-1:0]            item_width;
  logic                       item_average;

  assign rd_addr = CH_W'(channel);
  assign s1_addr = CH_W'(s1_channel);

  rpwc_ram #(
    .WIDTH ($bits(edge_entry_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (upd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    // last write is not yet visible at the ram read port
    priority if (fwd_valid && fwd_addr == s1_addr) begin
      cur = fwd_entry;
    end else if (s1_seen) begin
      cur = edge_entry_t'(rd_data);
    end else begin
      cur = '0;
    end
    upd.phase = !cur.phase;
    upd.start = cur.phase ? cur.start : s1_ts;
    if (s1_ts > cur.start) begin
      width = s1_ts - cur.start;
    end else begin
      width = TS_MAX - cur.start + s1_ts;
    end
    if (mask_bit(cfg_regs.wide_mask, s1_channel)) begin
      lo = cfg_regs.wide_low;
      hi = cfg_regs.wide_high;
    end else begin
      lo = cfg_regs.narrow_low;
      hi = cfg_regs.narrow_high;
    end
    pass = (width > lo) && (width < hi);
  end

  assign drop = s1_valid && !(cur.phase && pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      seen       <= '0;
      fwd_valid  <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      s1_valid   <= take;
      fwd_valid  <= s1_valid;
      item_valid <= s1_valid && cur.phase && pass;
      if (s1_valid) begin
        seen[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_channel   <= channel;
    s1_ts        <= timestamp;
    s1_seen      <= seen[rd_addr];
    fwd_addr     <= s1_addr;
    fwd_entry    <= upd;
    item_channel <= s1_channel;
    item_width   <= width;
    item_average <= mask_bit(cfg_regs.average_mask, s1_channel);
  end

  assign item = '{valid: item_valid, channel: item_channel, width: item_width,
                  average: item_average};
endmodule

FILE: sv/rpwc_scale.sv
// ----------------------------------------------------------------------------
// rpwc_scale
// Width to stick value scaling, per-channel averaging with sums in RAM.
// ----------------------------------------------------------------------------
module rpwc_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  rpwc_pkg::width_item_t item,
  output rpwc_pkg::result_t     result,
  output logic                  drop
);
  import rpwc_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } avg_entry_t;

  // product stage, also issues the sum read
  logic                 p_valid;
  logic [CHAN_W-1:0]    p_channel;
  logic                 p_average;
  logic [T_PROD_W-1:0]  p_prod;
  // read-modify-write stage
  logic                 r_valid;
  logic [CHAN_W-1:0]    r_channel;
  logic                 r_average;
  logic [VAL_W-1:0]     r_value;
  logic                 r_seen;
  // mean select stage
  logic                 m_valid;
  logic [CHAN_W-1:0]    m_channel;
  logic                 m_mean;
  logic [SUM_W-1:0]     m_sum;
  logic [VAL_W-1:0]     m_value;
  // mean product stage
  logic                 n_valid;
  logic [CHAN_W-1:0]    n_channel;
  logic                 n_mean;
  logic [VAL_W-1:0]     n_value;
  logic [A_PROD_W-1:0]  n_prod;

  logic [CHANNELS-1:0]  seen;
  logic                 fwd_valid;
  logic [CH_W-1:0]      fwd_addr;
  avg_entry_t           fwd_entry;
  logic [CH_W-1:0]      rd_addr;
  logic [CH_W-1:0]      r_addr;
  logic [$bits(avg_entry_t)-1:0] rd_data;
  logic [TS_W-1:0]      quot;
  logic [VAL_W-1:0]     scaled;
  avg_entry_t           cur;
  avg_entry_t           upd;
  logic [CNT_W:0]       count_inc;
  logic [SUM_W-1:0]     sum_next;
  logic                 done;
  logic                 wr_en;
  logic [SUM_W-1:0]     mean;
  logic [VAL_W-1:0]     mean_value;

  assign rd_addr = CH_W'(p_channel);
  assign r_addr  = CH_W'(r_channel);
  assign wr_en   = r_valid && r_average;

  rpwc_ram #(
    .WIDTH ($bits(avg_entry_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (r_addr),
    .wdata (upd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign quot   = TS_W'(p_prod >> T_SHIFT);
  assign scaled = (quot > TS_W'(VAL_MAX)) ? VAL_MAX : quot[VAL_W-1:0];

  always_comb begin
    priority if (fwd_valid && fwd_addr == r_addr) begin
      cur = fwd_entry;
    end else if (r_seen) begin
      cur = avg_entry_t'(rd_data);
    end else begin
      cur = '0;
    end
    count_inc = {1'b0, cur.count} + (CNT_W+1)'(1);
    sum_next  = cur.sum + SUM_W'(r_value);
    done      = count_inc >= (CNT_W+1)'(AVERAGE_LENGTH);
    if (done) begin
      upd = '0;
    end else begin
      upd.sum   = sum_next;
      upd.count = count_inc[CNT_W-1:0];
    end
  end

  assign drop = r_valid && r_average && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      seen      <= '0;
    end else begin
      p_valid   <= item.valid;
      r_valid   <= p_valid;
      m_valid   <= r_valid && (!r_average || done);
      n_valid   <= m_valid;
      fwd_valid <= wr_en;
      if (wr_en) begin
        seen[r_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_channel <= item.channel;
    p_average <= item.average;
    p_prod    <= item.width * T_RECIP;
    r_channel <= p_channel;
    r_average <= p_average;
    r_value   <= scaled;
    r_seen    <= seen[rd_addr];
    fwd_addr  <= r_addr;
    fwd_entry <= upd;
    m_channel <= r_channel;
    m_mean    <= r_average;
    m_sum     <= sum_next;
    m_value   <= r_value;
    n_channel <= m_channel;
    n_mean    <= m_mean;
    n_value   <= m_value;
    n_prod    <= m_sum * A_RECIP;
  end

  assign mean       = SUM_W'(n_prod >> A_SHIFT);
  assign mean_value = (mean > SUM_W'(VAL_MAX)) ? VAL_MAX : mean[VAL_W-1:0];

  assign result = '{valid: n_valid, channel: n_channel,
                    value: n_mean ? mean_value : n_value};
endmodule

FILE: sv/rpwc_queue.sv
// ----------------------------------------------------------------------------
// rpwc_queue
// Result queue with credit count of items still in the datapath.
// ----------------------------------------------------------------------------
module rpwc_queue (
  input  logic              clk,
  input  logic              rst,
  input  rpwc_pkg::credit_t credit,
  input  rpwc_pkg::result_t push,
  output logic              space,
  rpwc_res_if.source        res
);
  import rpwc_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
  } slot_t;

  slot_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  pending;
  logic [QCNT_W-1:0]  pending_next;
  logic               pop;

  assign pop   = res.valid && res.ready;
  assign space = pending < QCNT_W'(QUEUE_DEPTH);

  // every accepted item holds a credit until it is dropped or its result transfers
  assign pending_next = pending + QCNT_W'(credit.take) - QCNT_W'(credit.edge_drop)
                        - QCNT_W'(credit.scale_drop) - QCNT_W'(pop);

  assign res.valid       = count != '0;
  assign res.out_channel = slots[rd_ptr].channel;
  assign res.stick_value = slots[rd_ptr].value;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      pending <= pending_next;
      count   <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= '{channel: push.channel, value: push.value};
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= QCNT_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    count <= pending)
    else $error("queue holds more results than credits");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (count < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("result pushed into full queue");

  a_take_needs_space: assert property (@(posedge clk) disable iff (rst)
    credit.take |=> pending != '0)
    else $error("accepted item lost its credit");
`endif
endmodule

FILE: sv/rc_pulse_width_capture_top.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_top
// RC receiver pulse width capture with window filter and averaging.
// ----------------------------------------------------------------------------
// evt carries capture edges (channel, timestamp); channels >= 6 are ignored.
// The first edge of a channel latches its start time, the next one measures
// the width, checks it against the narrow or wide window, divides it by the
// tick scale and, for averaging channels, sums five values before reporting
// the mean. res carries one (out_channel, stick_value) per reported pulse.
// cfg writes the window bounds and the two channel masks; it is always ready
// and should be written only while no event is in flight.
// An end edge passes edge stages s1, item and scale stages p, r, m, n before
// its result enters the queue. One event per cycle is taken while there is
// space; each RAM (phase/start, sum/count) is read the cycle before it is
// written, with a bypass of the last write, so same-channel edges may arrive
// back to back. A queue of 8 results sits in front of res. evt.ready falls
// only when 8 accepted events have not yet resolved, so a stalled receiver
// backs up the input after 8 items and nothing is lost.
// Reset clears every channel to awaiting a start edge with zero sum and count
// through per-entry valid bits and loads the default register values.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture_top (
  input  logic        clk,
  input  logic        rst,
  rpwc_evt_if.sink    evt,
  rpwc_res_if.source  res,
  rpwc_cfg_if.sink    cfg
);
  import rpwc_pkg::*;

  cfg_t          cfg_regs;
  credit_t       credit;
  width_item_t   width_item;
  result_t       result;
  logic          space;
  logic          take;
  logic          edge_drop;
  logic          scale_drop;

  assign cfg.ready = 1'b1;
  assign evt.ready = space;
  assign take      = evt.valid && evt.ready && (int'(evt.channel) < CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.narrow_low   <= NARROW_LOW_RST;
      cfg_regs.narrow_high  <= NARROW_HIGH_RST;
      cfg_regs.wide_low     <= WIDE_LOW_RST;
      cfg_regs.wide_high    <= WIDE_HIGH_RST;
      cfg_regs.wide_mask    <= WIDE_MASK_RST;
      cfg_regs.average_mask <= AVERAGE_MASK_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_NARROW_LOW:   cfg_regs.narrow_low   <= cfg.data[TS_W-1:0];
        CFG_NARROW_HIGH:  cfg_regs.narrow_high  <= cfg.data[TS_W-1:0];
        CFG_WIDE_LOW:     cfg_regs.wide_low     <= cfg.data[TS_W-1:0];
        CFG_WIDE_HIGH:    cfg_regs.wide_high    <= cfg.data[TS_W-1:0];
        CFG_WIDE_MASK:    cfg_regs.wide_mask    <= cfg.data[MASK_W-1:0];
        CFG_AVERAGE_MASK: cfg_regs.average_mask <= cfg.data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpwc_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .channel   (evt.channel),
    .timestamp (evt.timestamp),
    .cfg_regs  (cfg_regs),
    .item      (width_item),
    .drop      (edge_drop)
  );

  rpwc_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .item   (width_item),
    .result (result),
    .drop   (scale_drop)
  );

  assign credit = '{take: take, edge_drop: edge_drop, scale_drop: scale_drop};

  rpwc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .credit (credit),
    .push   (result),
    .space  (space),
    .res    (res)
  );
endmodule
